// File: sv/pba_pkg.sv
package pba_pkg;

	// Field widths of the request and response transfers.
	localparam int OP_W = 2;
	localparam int BYTES_W = 28;
	localparam int ADDR_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 16;
	localparam int WORD_BITS = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USABLE_PAGES = 1'b1;

	// Register values after reset.
	localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'd3145728;
	localparam logic [COUNT_W-1:0] USABLE_PAGES_RESET = 16'd32000;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE = 2'd1,
		OP_RESERVE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK = 2'd0,
		STAT_NO_RUN = 2'd1,
		STAT_BAD = 2'd2,
		STAT_SAME = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_PAGE,
		S_RESP
	} state_t;

endpackage

// File: sv/pba_if.sv
interface pba_req_if;
	logic valid;
	logic ready;
	logic [pba_pkg::OP_W-1:0] op;
	logic [pba_pkg::BYTES_W-1:0] request_bytes;
	logic [pba_pkg::ADDR_W-1:0] page_address;
	modport source (output valid, op, request_bytes, page_address, input ready);
	modport sink (input valid, op, request_bytes, page_address, output ready);
endinterface

interface pba_rsp_if;
	logic valid;
	logic ready;
	logic [pba_pkg::ADDR_W-1:0] result_address;
	logic [pba_pkg::STATUS_W-1:0] status;
	logic [pba_pkg::COUNT_W-1:0] free_pages;
	modport source (output valid, result_address, status, free_pages, input ready);
	modport sink (input valid, result_address, status, free_pages, output ready);
endinterface

interface pba_cfg_if;
	logic valid;
	logic ready;
	logic [pba_pkg::CFG_IDX_W-1:0] index;
	logic [pba_pkg::ADDR_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pba_ram.sv
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/pba_scan.sv
module pba_scan #(
	parameter int RUN_W = 16,
	parameter int NEED_W = 17
) (
	input  logic [pba_pkg::WORD_BITS-1:0] word_data,
	input  logic [31:0]                   base,
	input  logic [RUN_W-1:0]              run_in,
	input  logic [NEED_W-1:0]             need,
	input  logic [pba_pkg::COUNT_W-1:0]   total,
	output logic                          hit,
	output logic [4:0]                    hit_bit,
	output logic [RUN_W-1:0]              run_out
);

	logic [31:0]           used;
	logic [31:0]           any_used;
	logic [31:0][4:0]      last_used;
	logic [31:0][RUN_W-1:0] run_b;
	logic [31:0]           hit_b;

	// Pages past the managed range count as used.
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			used[b] = word_data[b] | ~((base + 32'(b)) < 32'(total));
		end
	end

	// Free run length ending at each bit, carried in from earlier words.
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			any_used[b] = 1'b0;
			last_used[b] = '0;
			for (int k = 0; k < 32; k++) begin
				if (k <= b && used[k]) begin
					any_used[b] = 1'b1;
					last_used[b] = 5'(k);
				end
			end
			run_b[b] = any_used[b] ? RUN_W'(b) - RUN_W'(last_used[b])
			                       : run_in + RUN_W'(b + 1);
			hit_b[b] = 32'(run_b[b]) >= 32'(need);
		end
	end

	// Lowest bit at which the run reaches the requested length.
	always_comb begin
		hit = |hit_b;
		hit_bit = '0;
		for (int b = 31; b >= 0; b--) begin
			if (hit_b[b]) begin
				hit_bit = 5'(b);
			end
		end
		run_out = any_used[31] ? RUN_W'(31) - RUN_W'(last_used[31]) : run_in + RUN_W'(32);
	end

endmodule

// File: sv/page_bitmap_allocator_core.sv
// A rejected request goes from idle straight to the response state; free and reserve
// pass through the page state first. Allocate scans the map word by word, then marks
// the words of the run found (and answers with no run when none is found), one word at
// a time through the single read port of the map memory, read as 32-bit words.
// One request at a time; the next request is taken after the response loads.
// Reset: a clearing pass rewrites every word of the map.
module page_bitmap_allocator_core #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGE_COUNT = 32768,
	parameter int RESERVED_AT_RESET = 32,
	parameter longint MEM_TOP = 134217728
) (
	input  logic clk,
	input  logic arst_n,
	pba_cfg_if.sink   cfg,
	pba_req_if.sink   req,
	pba_rsp_if.source rsp
);

	localparam int PS = $clog2(PAGE_BYTES);
	localparam int PW = $clog2(MAX_PAGE_COUNT);
	localparam int WORDS = (MAX_PAGE_COUNT + 31) / 32;
	localparam int WAW = $clog2(WORDS);
	localparam int NEED_W = 29 - PS;
	localparam int RUN_W = $clog2(MAX_PAGE_COUNT + 33);
	localparam int CW = $clog2(MAX_PAGE_COUNT + 1);
	localparam int RN = RESERVED_AT_RESET > MAX_PAGE_COUNT ? MAX_PAGE_COUNT
	                                                      : RESERVED_AT_RESET;
	localparam logic [32:0] MEM_TOP_V = 33'(MEM_TOP);

	pba_pkg::state_t state_q, state_d;

	logic [31:0]       heap_base_q;
	logic [15:0]       usable_q;
	logic [15:0]       total;
	logic [CW-1:0]     used_q;
	logic [WAW-1:0]    clr_q;
	logic [WAW:0]      word_q;
	logic [WAW:0]      word_s1;
	logic              rd_vld_s1;
	logic [RUN_W-1:0]  run_q;
	logic [NEED_W-1:0] need_q;
	logic [PW-1:0]     start_q;
	logic [PW-1:0]     end_q;
	logic [WAW:0]      mark_w_q;
	logic [PW-1:0]     idx_q;
	logic [pba_pkg::OP_W-1:0] op_q;
	logic [1:0]        status_q;
	logic [31:0]       addr_q;

	logic              rsp_valid_q;
	logic [31:0]       rsp_addr_q;
	logic [1:0]        rsp_status_q;
	logic [15:0]       rsp_free_q;

	// Request decode.
	logic              req_xfer;
	logic [NEED_W-1:0] need;
	logic [31:0]       rel;
	logic [31:0]       pidx_full;
	logic              pidx_ok;
	logic              op_ok;

	// Map memory ports.
	logic              mem_we;
	logic [WAW-1:0]    mem_waddr;
	logic [31:0]       mem_wdata;
	logic [WAW-1:0]    mem_raddr;
	logic [31:0]       mem_rdata;
	logic              issue;

	// Scan unit.
	logic              scan_hit;
	logic [4:0]        scan_bit;
	logic [RUN_W-1:0]  scan_run;
	logic [31:0]       scan_base;
	logic [31:0]       hit_end;
	logic [31:0]       hit_start;
	logic              scan_last;
	logic [WAW:0]      start_w;
	logic [WAW:0]      end_w;
	logic [31:0]       clr_pattern;
	logic [31:0]       mark_mask;
	logic [4:0]        mark_lo;
	logic [4:0]        mark_hi;
	logic              page_bit;

	assign total = (32'(usable_q) > 32'(MAX_PAGE_COUNT)) ? 16'(MAX_PAGE_COUNT) : usable_q;

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == pba_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	// Page count of the request, rounded up.
	assign need = NEED_W'((29'(req.request_bytes) + 29'(PAGE_BYTES - 1)) >> PS);

	// Page index of the address and its range check.
	assign rel = req.page_address - heap_base_q;
	assign pidx_full = rel >> PS;
	assign pidx_ok = (req.page_address >= heap_base_q)
	              && (33'(req.page_address) < MEM_TOP_V)
	              && (pidx_full < 32'(total));
	assign op_ok = (req.op == pba_pkg::OP_RESERVE)
	            || ((req.op == pba_pkg::OP_FREE) && (req.page_address != '0));

	// Word evaluation during the first-fit scan.
	assign scan_base = 32'(word_s1) << 5;
	assign hit_end = scan_base + 32'(scan_bit);
	assign hit_start = hit_end + 32'd1 - 32'(need_q);
	assign scan_last = (scan_base + 32'd32) >= 32'(total);
	assign start_w = (WAW + 1)'(start_q >> 5);
	assign end_w = (WAW + 1)'(end_q >> 5);

	pba_scan #(
		.RUN_W (RUN_W),
		.NEED_W(NEED_W)
	) u_scan (
		.word_data(mem_rdata),
		.base     (scan_base),
		.run_in   (run_q),
		.need     (need_q),
		.total    (total),
		.hit      (scan_hit),
		.hit_bit  (scan_bit),
		.run_out  (scan_run)
	);

	// Reset contents of one map word.
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			clr_pattern[b] = (32'(clr_q) * 32 + 32'(b)) < 32'(RN);
		end
	end

	// Bits of the current word that fall inside the allocated run.
	assign mark_lo = (word_s1 == start_w) ? start_q[4:0] : 5'd0;
	assign mark_hi = (word_s1 == end_w) ? end_q[4:0] : 5'd31;
	assign mark_mask = ({32{1'b1}} << mark_lo) & ({32{1'b1}} >> (5'd31 - mark_hi));
	assign page_bit = mem_rdata[idx_q[4:0]];

	pba_ram #(
		.WIDTH(32),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pba_pkg::S_CLEAR: begin
				if (32'(clr_q) == 32'(WORDS - 1)) begin
					state_d = pba_pkg::S_IDLE;
				end
			end
			pba_pkg::S_IDLE: begin
				if (req_xfer) begin
					if (req.op == pba_pkg::OP_ALLOC && req.request_bytes != '0
					    && 32'(need) <= 32'(total)) begin
						state_d = pba_pkg::S_SCAN;
					end else if (op_ok && pidx_ok) begin
						state_d = pba_pkg::S_PAGE;
					end else begin
						state_d = pba_pkg::S_RESP;
					end
				end
			end
			pba_pkg::S_SCAN: begin
				if (rd_vld_s1 && scan_hit) begin
					state_d = pba_pkg::S_MARK;
				end else if (rd_vld_s1 && scan_last) begin
					state_d = pba_pkg::S_RESP;
				end
			end
			pba_pkg::S_MARK: begin
				if (rd_vld_s1 && word_s1 == end_w) begin
					state_d = pba_pkg::S_RESP;
				end
			end
			pba_pkg::S_PAGE: state_d = pba_pkg::S_RESP;
			pba_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = pba_pkg::S_IDLE;
				end
			end
			default: state_d = pba_pkg::S_CLEAR;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = WAW'(pidx_full >> 5);
		issue = 1'b0;
		case (state_q)
			pba_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = clr_pattern;
			end
			pba_pkg::S_SCAN: begin
				mem_raddr = word_q[WAW-1:0];
				issue = ((32'(word_q) << 5) < 32'(total)) && !(rd_vld_s1 && scan_hit);
			end
			pba_pkg::S_MARK: begin
				mem_raddr = mark_w_q[WAW-1:0];
				issue = (mark_w_q <= end_w);
				mem_we = rd_vld_s1;
				mem_waddr = word_s1[WAW-1:0];
				mem_wdata = mem_rdata | mark_mask;
			end
			pba_pkg::S_PAGE: begin
				mem_waddr = WAW'(idx_q >> 5);
				if (op_q == pba_pkg::OP_FREE) begin
					mem_we = page_bit;
					mem_wdata = mem_rdata & ~(32'd1 << idx_q[4:0]);
				end else begin
					mem_we = !page_bit;
					mem_wdata = mem_rdata | (32'd1 << idx_q[4:0]);
				end
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pba_pkg::S_CLEAR;
			clr_q <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			heap_base_q <= pba_pkg::HEAP_BASE_RESET;
			usable_q <= pba_pkg::USABLE_PAGES_RESET;
			used_q <= CW'(RN);
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == pba_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					pba_pkg::CFG_HEAP_BASE: heap_base_q <= cfg.data;
					pba_pkg::CFG_USABLE_PAGES: usable_q <= cfg.data[15:0];
					default: usable_q <= usable_q;
				endcase
			end
			// Used-page count follows each change of the map.
			if (state_q == pba_pkg::S_MARK && rd_vld_s1 && word_s1 == end_w) begin
				used_q <= used_q + CW'(need_q);
			end else if (state_q == pba_pkg::S_PAGE) begin
				if (op_q == pba_pkg::OP_FREE && page_bit && used_q != '0) begin
					used_q <= used_q - 1'b1;
				end else if (op_q != pba_pkg::OP_FREE && !page_bit) begin
					used_q <= used_q + 1'b1;
				end
			end
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == pba_pkg::S_RESP && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		word_s1 <= (state_q == pba_pkg::S_MARK) ? mark_w_q : word_q;
		if (issue) begin
			if (state_q == pba_pkg::S_MARK) begin
				mark_w_q <= mark_w_q + 1'b1;
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
		case (state_q)
			pba_pkg::S_IDLE: begin
				word_q <= '0;
				run_q <= '0;
				need_q <= need;
				op_q <= req.op;
				idx_q <= PW'(pidx_full);
				addr_q <= '0;
				if (req.op == pba_pkg::OP_ALLOC && req.request_bytes != '0) begin
					status_q <= pba_pkg::STAT_NO_RUN;
				end else begin
					status_q <= pba_pkg::STAT_BAD;
				end
			end
			pba_pkg::S_SCAN: begin
				if (rd_vld_s1) begin
					run_q <= scan_run;
					start_q <= PW'(hit_start);
					end_q <= PW'(hit_end);
					mark_w_q <= (WAW + 1)'(hit_start >> 5);
				end
			end
			pba_pkg::S_MARK: begin
				if (rd_vld_s1 && word_s1 == end_w) begin
					status_q <= pba_pkg::STAT_OK;
					addr_q <= heap_base_q + (32'(start_q) << PS);
				end
			end
			pba_pkg::S_PAGE: begin
				if ((op_q == pba_pkg::OP_FREE) == page_bit) begin
					status_q <= pba_pkg::STAT_OK;
				end else begin
					status_q <= pba_pkg::STAT_SAME;
				end
			end
			pba_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_addr_q <= addr_q;
					rsp_status_q <= status_q;
					rsp_free_q <= (32'(used_q) < 32'(total))
					            ? 16'(32'(total) - 32'(used_q)) : 16'd0;
				end
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.result_address = rsp_addr_q;
	assign rsp.status = rsp_status_q;
	assign rsp.free_pages = rsp_free_q;

	// The count of used pages never passes the map size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(MAX_PAGE_COUNT))
		else $error("used page count out of range");

	// Writes while marking stay inside the words of the run.
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pba_pkg::S_MARK && mem_we) |-> (word_s1 >= start_w && word_s1 <= end_w))
		else $error("mark write outside the allocated run");

	// A request transfer always starts work on it.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> (state_q != pba_pkg::S_IDLE))
		else $error("request taken but block stayed idle");

	// No request is taken while the map is being rewritten.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pba_pkg::S_CLEAR) |-> !req.ready)
		else $error("request ready during clearing pass");

endmodule

// File: verif/page_bitmap_allocator_core_if.sv
`timescale 1ns / 100ps

// File: verif/page_bitmap_allocator_core_test.sv
`timescale 1ns / 100ps

module page_bitmap_allocator_core_test;

	localparam int PG_BYTES = 4096;
	localparam int MAP_PAGES = 32768;
	localparam int RESERVED = 32;
	localparam longint TOP = 134217728;
	localparam int WATCHDOG = 40000;
	localparam logic [pba_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

	typedef struct packed {
		logic [pba_pkg::ADDR_W-1:0] addr;
		logic [pba_pkg::STATUS_W-1:0] status;
		logic [pba_pkg::COUNT_W-1:0] free_pages;
	} answer_t;

	// Tracks the page map and predicts the answer to every request.
	class alloc_scoreboard;
		bit page_map [MAP_PAGES];
		int unsigned taken_count;
		logic [pba_pkg::ADDR_W-1:0] base;
		logic [pba_pkg::COUNT_W-1:0] usable;
		answer_t pending [$];
		int mismatches;

		function new();
			for (int i = 0; i < MAP_PAGES; i++)
				page_map[i] = (i < RESERVED);
			taken_count = RESERVED;
			base = pba_pkg::HEAP_BASE_RESET;
			usable = pba_pkg::USABLE_PAGES_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [pba_pkg::CFG_IDX_W-1:0] idx,
				logic [pba_pkg::ADDR_W-1:0] value);
			if (idx == pba_pkg::CFG_HEAP_BASE)
				base = value;
			else
				usable = value[pba_pkg::COUNT_W-1:0];
		endfunction

		function longint page_of(logic [pba_pkg::ADDR_W-1:0] a, int unsigned total);
			longint p;
			if (a < base || longint'(a) >= TOP)
				return -1;
			p = longint'(a - base) / PG_BYTES;
			if (p >= total)
				return -1;
			return p;
		endfunction

		// Predicts the answer to one accepted request and updates the map.
		function void note_request(logic [pba_pkg::OP_W-1:0] op,
				logic [pba_pkg::BYTES_W-1:0] nbytes, logic [pba_pkg::ADDR_W-1:0] a);
			answer_t ans;
			int unsigned total;
			longint need;
			longint p;
			int unsigned run;
			int unsigned first;
			total = (usable > MAP_PAGES) ? MAP_PAGES : usable;
			ans.addr = '0;
			ans.status = pba_pkg::STAT_BAD;
			if (op == pba_pkg::OP_ALLOC) begin
				if (nbytes != 0) begin
					need = (longint'(nbytes) + PG_BYTES - 1) / PG_BYTES;
					ans.status = pba_pkg::STAT_NO_RUN;
					if (need <= total) begin
						run = 0;
						for (int i = 0; i < total; i++) begin
							run = page_map[i] ? 0 : run + 1;
							if (run == need) begin
								first = i + 1 - run;
								for (int j = first; j <= i; j++)
									page_map[j] = 1;
								taken_count += run;
								ans.addr = base + first * PG_BYTES;
								ans.status = pba_pkg::STAT_OK;
								break;
							end
						end
					end
				end
			end else if (op == pba_pkg::OP_FREE) begin
				p = (a != 0) ? page_of(a, total) : -1;
				if (p >= 0) begin
					if (!page_map[p]) begin
						ans.status = pba_pkg::STAT_SAME;
					end else begin
						page_map[p] = 0;
						if (taken_count != 0)
							taken_count--;
						ans.status = pba_pkg::STAT_OK;
					end
				end
			end else if (op == pba_pkg::OP_RESERVE) begin
				p = page_of(a, total);
				if (p >= 0) begin
					if (page_map[p]) begin
						ans.status = pba_pkg::STAT_SAME;
					end else begin
						page_map[p] = 1;
						taken_count++;
						ans.status = pba_pkg::STAT_OK;
					end
				end
			end
			ans.free_pages = pba_pkg::COUNT_W'((taken_count < total) ?
				total - taken_count : 0);
			pending.push_back(ans);
		endfunction

		// Compares one response with the oldest prediction.
		function void check_answer(answer_t got);
			answer_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response addr=%h status=%0d free=%0d",
						got.addr, got.status, got.free_pages);
				return;
			end
			exp = pending.pop_front();
			if (got.addr !== exp.addr || got.status !== exp.status ||
					got.free_pages !== exp.free_pages) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp addr=%h status=%0d free=%0d, got addr=%h status=%0d free=%0d",
						exp.addr, exp.status, exp.free_pages,
						got.addr, got.status, got.free_pages);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pba_cfg_if cfg ();
	pba_req_if req ();
	pba_rsp_if rsp ();

	alloc_scoreboard board;
	bit calm;
	int idle_cycles;

	page_bitmap_allocator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Note each request transfer and check each response transfer.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.note_request(req.op, req.request_bytes, req.page_address);
		if (arst_n && rsp.valid && rsp.ready)
			board.check_answer({rsp.result_address, rsp.status, rsp.free_pages});
	end

	// Watchdog on cycles with no transfer.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response ready with random stall bursts.
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 8);
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// The extra edge keeps back-to-back writes from dropping and raising valid at once.
	task automatic write_reg(logic [pba_pkg::CFG_IDX_W-1:0] idx,
			logic [pba_pkg::ADDR_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		board.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Valid stays high into the next request and is dropped only for a gap or by drain.
	task automatic send_request(logic [pba_pkg::OP_W-1:0] op,
			logic [pba_pkg::BYTES_W-1:0] nbytes, logic [pba_pkg::ADDR_W-1:0] a);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.request_bytes <= nbytes;
		req.page_address <= a;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Waits until every answer has arrived, then lets the block settle.
	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Address of a page near the managed window, sometimes unaligned.
	function automatic logic [pba_pkg::ADDR_W-1:0] pick_addr();
		int unsigned span;
		logic [pba_pkg::ADDR_W-1:0] a;
		span = (board.usable > MAP_PAGES) ? MAP_PAGES : board.usable;
		case ($urandom_range(0, 9))
			0: a = $urandom();
			1: a = board.base - $urandom_range(1, 8192);
			2: a = board.base + (span + $urandom_range(0, 3)) * PG_BYTES;
			3: a = 32'd0;
			default: a = board.base + $urandom_range(0, span + 1) * PG_BYTES;
		endcase
		if ($urandom_range(0, 4) == 0)
			a = a + $urandom_range(1, PG_BYTES - 1);
		return a;
	endfunction

	// One phase of random requests, mostly small allocations and page ops.
	task automatic random_phase(int count);
		logic [pba_pkg::OP_W-1:0] op;
		logic [pba_pkg::BYTES_W-1:0] nbytes;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0: op = OP_UNDEF;
				1, 2, 3, 4, 5, 6: op = pba_pkg::OP_ALLOC;
				7, 8, 9, 10, 11, 12: op = pba_pkg::OP_FREE;
				default: op = pba_pkg::OP_RESERVE;
			endcase
			case ($urandom_range(0, 9))
				0: nbytes = pba_pkg::BYTES_W'($urandom());
				1: nbytes = 0;
				default: nbytes = pba_pkg::BYTES_W'($urandom_range(1, 8 * PG_BYTES));
			endcase
			send_request(op, nbytes, pick_addr());
		end
	endtask

	// Stimulus sequence.
	initial begin
		board = new();
		calm = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= pba_pkg::CFG_HEAP_BASE;
		cfg.data <= '0;
		req.valid <= 1'b0;
		req.op <= pba_pkg::OP_ALLOC;
		req.request_bytes <= '0;
		req.page_address <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset settings.
		send_request(pba_pkg::OP_ALLOC, 28'd0, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd1, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd4096, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd4097, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'hFFFFFFF, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd134217728 - 28'd1, 32'd0);
		send_request(pba_pkg::OP_FREE, '0, 32'd0);
		send_request(pba_pkg::OP_FREE, '0, pba_pkg::HEAP_BASE_RESET);
		send_request(pba_pkg::OP_FREE, '0, pba_pkg::HEAP_BASE_RESET);
		send_request(pba_pkg::OP_RESERVE, '0, pba_pkg::HEAP_BASE_RESET + 32'd5);
		send_request(pba_pkg::OP_RESERVE, '0, pba_pkg::HEAP_BASE_RESET + 32'd4);
		send_request(pba_pkg::OP_RESERVE, '0, pba_pkg::HEAP_BASE_RESET - 32'd1);
		send_request(pba_pkg::OP_RESERVE, '0, 32'd134217728);
		send_request(pba_pkg::OP_FREE, '0, 32'hFFFFFFFF);
		send_request(pba_pkg::OP_RESERVE, '0,
			pba_pkg::HEAP_BASE_RESET + 32'd31999 * PG_BYTES);
		send_request(pba_pkg::OP_RESERVE, '0,
			pba_pkg::HEAP_BASE_RESET + 32'd32000 * PG_BYTES);
		send_request(OP_UNDEF, 28'hFFFFFFF, 32'hFFFFFFFF);
		drain();

		// Tiny window: allocations fail, free at zero count.
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd1, 32'd0);
		send_request(pba_pkg::OP_FREE, '0, pba_pkg::HEAP_BASE_RESET);
		drain();
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'd40);
		write_reg(pba_pkg::CFG_HEAP_BASE, 32'd0);
		send_request(pba_pkg::OP_FREE, '0, 32'd4096);
		send_request(pba_pkg::OP_FREE, '0, 32'd8);
		send_request(pba_pkg::OP_ALLOC, 28'd16 * 28'd4096, 32'd0);
		send_request(pba_pkg::OP_ALLOC, 28'd1, 32'd0);
		random_phase(60);
		drain();

		// Top of address space with the largest window.
		write_reg(pba_pkg::CFG_HEAP_BASE, 32'hFFFFF000);
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'hFFFF);
		send_request(pba_pkg::OP_ALLOC, 28'd4096, 32'd0);
		send_request(pba_pkg::OP_RESERVE, '0, 32'hFFFFF000);
		random_phase(40);
		drain();

		write_reg(pba_pkg::CFG_HEAP_BASE, 32'h0010_0000);
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'd32768);
		random_phase(160);
		drain();

		write_reg(pba_pkg::CFG_HEAP_BASE, 32'h0800_0000 - 32'd64 * PG_BYTES);
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'd200);
		random_phase(150);
		drain();

		// Final phase with no idling on either side.
		write_reg(pba_pkg::CFG_HEAP_BASE, pba_pkg::HEAP_BASE_RESET);
		write_reg(pba_pkg::CFG_USABLE_PAGES, 32'd300);
		calm = 1;
		random_phase(140);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
